>>> rtl/core/trimmed_mean_current_soc_defines.svh
// assertion macros shared by the trimmed mean current and charge estimate block
`ifndef TRIMMED_MEAN_CURRENT_SOC_DEFINES_SVH
`define TRIMMED_MEAN_CURRENT_SOC_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TMCS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define TMCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/tmcs_pkg.sv
// shared types and constants of the trimmed mean current and charge estimate block
`default_nettype none

package tmcs_pkg;

   // field widths
   localparam int CUR_W        = 16;
   localparam int BUS_W        = 13;
   localparam int COUNT_CFG_W  = 6;
   localparam int STEP_W       = 16;
   localparam int MV_W         = 15;
   localparam int SOC_W        = 10;

   // configuration port
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_COUNT = 2'd0,
      CSR_VOLT_STEP    = 2'd1,
      CSR_VOLT_LOW     = 2'd2,
      CSR_VOLT_HIGH    = 2'd3
   } csr_index_type;

   // configuration reset values
   localparam logic [COUNT_CFG_W-1:0] SAMPLE_COUNT_RST = 6'd10;
   localparam logic [STEP_W-1:0]      VOLT_STEP_RST    = 16'd4000;
   localparam logic [MV_W-1:0]        VOLT_LOW_RST     = 15'd12220;
   localparam logic [MV_W-1:0]        VOLT_HIGH_RST    = 15'd12860;

   // batch constants
   localparam int MIN_COUNT    = 5;
   localparam int TRIM_DROP    = 4;

   // charge estimate arithmetic
   localparam int UV_W         = BUS_W + STEP_W;   // bus microvolts
   localparam int DEN_W        = 25;               // millivolts times 1000
   localparam int T_W          = 31;               // signed offset numerator
   localparam int DIV_W        = 39;               // divider dividend and quotient
   localparam int DIV_CNT_W    = 6;
   localparam int MV_TO_UV     = 1000;
   localparam int SOC_SCALE    = 500;
   localparam logic [SOC_W-1:0] SOC_FULL = 10'd1000;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRIM,
      ST_MEAN_START,
      ST_MEAN_DIV,
      ST_SOC_START,
      ST_SOC_DIV,
      ST_FINISH
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic trim;
      logic mean_start;
      logic mean_take;
      logic soc_start;
      logic soc_take;
      logic publish;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_sample;
      logic div_done;
      logic div_busy;
      logic soc_div_needed;
      logic out_free;
   } dp_status_type;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

>>> rtl/core/tmcs_if.sv
// sample and result channel interfaces
`default_nettype none

interface tmcs_req_if import tmcs_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [CUR_W-1:0] current_code;
   logic [BUS_W-1:0]        bus_code;

   modport source (output valid, output current_code, output bus_code, input ready);
   modport sink   (input valid, input current_code, input bus_code, output ready);
endinterface

interface tmcs_rsp_if import tmcs_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [CUR_W-1:0] avg_current_code;
   logic [SOC_W-1:0]        soc_permille;
   logic                    soc_valid;

   modport source (output valid, output avg_current_code, output soc_permille,
                   output soc_valid, input ready);
   modport sink   (input valid, input avg_current_code, input soc_permille,
                   input soc_valid, output ready);
endinterface

`default_nettype wire

>>> rtl/core/trimmed_mean_current_soc.sv
// top level of the trimmed mean current and charge estimate block
`default_nettype none

// Takes batches of signed current samples (sample_count per batch, held to
// 5..MAX_SAMPLES) and, after the last sample of each batch, returns one
// transaction: the batch mean with the two smallest and two largest samples
// dropped, truncated toward zero, plus a state of charge in permille mapped
// linearly from the bus voltage of the first sample when the trimmed sum is
// negative. Samples are taken one per cycle while a batch is filling. After
// the last sample the block takes no new sample until it has run one trim
// step, then two passes of a shared one-bit-per-cycle divider (trimmed mean,
// then charge estimate), each a start step plus 39 steps plus a done step,
// and a finish step that loads the output register. The second pass is
// skipped when no charge estimate is needed. The finish step stretches
// while the previous result is still waiting in the output register.
// A finished result waits in that register, so the next batch can start
// filling before the previous result is taken.
// Configuration is written through csr_we, csr_index and csr_wdata.

`include "trimmed_mean_current_soc_defines.svh"

module trimmed_mean_current_soc import tmcs_pkg::*; #(
   parameter int MAX_SAMPLES = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   tmcs_req_if.sink                   req_ch,
   tmcs_rsp_if.source                 rsp_ch,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type     dp_cmd;
   dp_status_type  dp_status;
   ctrl_state_type ctrl_state;

   // sequencer
   tmcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (dp_status),
      .cmd       (dp_cmd),
      .state     (ctrl_state)
   );

   // datapath
   tmcs_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .status           (dp_status),
      .current_code     (req_ch.current_code),
      .bus_code         (req_ch.bus_code),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .avg_current_code (rsp_ch.avg_current_code),
      .soc_permille     (rsp_ch.soc_permille),
      .soc_valid        (rsp_ch.soc_valid)
   );

   // checks
   `TMCS_ASSERT_IMPL(a_rsp_after_finish, clock, reset, $rose(rsp_ch.valid), $past(ctrl_state == ST_FINISH), "result raised outside finish")
   `TMCS_ASSERT_IMPL(a_soc_range, clock, reset, rsp_ch.valid, (rsp_ch.soc_permille <= SOC_FULL) && (rsp_ch.soc_valid || (rsp_ch.soc_permille == '0)), "charge estimate out of range")
   `TMCS_ASSERT_NEXT(a_last_starts_trim, clock, reset, req_ch.valid && req_ch.ready && dp_status.last_sample, ctrl_state == ST_TRIM, "last sample did not end batch")
   `TMCS_ASSERT_IMPL(a_div_busy_state, clock, reset, dp_status.div_busy, (ctrl_state == ST_MEAN_DIV) || (ctrl_state == ST_SOC_DIV), "divider busy outside divide state")

endmodule

`default_nettype wire

>>> rtl/core/tmcs_divider.sv
// unsigned restoring divider, one quotient bit per cycle
`default_nettype none

module tmcs_divider import tmcs_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output logic [DIV_W-1:0]      quotient,
   output div_status_type        status
);

   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DEN_W-1:0]     div_ff, div_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DEN_W:0]       partial;
   logic                 fits;

   // one restoring step
   always_comb begin
      partial = {rem_ff, quo_ff[DIV_W-1]};
      fits    = partial >= {1'b0, div_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         cnt_in  = DIV_CNT_W'(DIV_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(partial - {1'b0, div_ff}) : DEN_W'(partial);
         quo_in = {quo_ff[DIV_W-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - DIV_CNT_W'(1);
         end
      end
   end

   // control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

>>> rtl/core/tmcs_datapath.sv
// sample accumulation, extreme tracking, trimmed mean and charge estimate datapath
`default_nettype none

module tmcs_datapath import tmcs_pkg::*; #(
   parameter int MAX_SAMPLES = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire dp_cmd_type              cmd,
   output dp_status_type                status,
   input  wire logic signed [CUR_W-1:0] current_code,
   input  wire logic [BUS_W-1:0]        bus_code,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                    rsp_ready,
   output logic                         rsp_valid,
   output logic signed [CUR_W-1:0]      avg_current_code,
   output logic [SOC_W-1:0]             soc_permille,
   output logic                         soc_valid
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int CMP_W = (CNT_W > COUNT_CFG_W) ? CNT_W : COUNT_CFG_W;
   localparam int SUM_W = CUR_W + $clog2(MAX_SAMPLES) + 1;

   // configuration registers
   logic [COUNT_CFG_W-1:0] sample_count_ff;
   logic [STEP_W-1:0]      volt_step_ff;
   logic [MV_W-1:0]        volt_low_ff;
   logic [MV_W-1:0]        volt_high_ff;

   // batch state
   logic [CNT_W-1:0]        seen_ff, seen_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [CUR_W-1:0] small0_ff, small0_in, small1_ff, small1_in;
   logic signed [CUR_W-1:0] large0_ff, large0_in, large1_ff, large1_in;
   logic [BUS_W-1:0]        bus_ff, bus_in;

   // end of batch
   logic signed [SUM_W-1:0] trimmed_ff;
   logic [UV_W-1:0]         uv_ff;
   logic [DEN_W-1:0]        low_uv_ff, high_uv_ff;
   logic [T_W-1:0]          t_ff;
   logic [DIV_W-1:0]        soc_num_ff;
   logic signed [CUR_W-1:0] mean_ff;
   logic [SOC_W-1:0]        soc_ff;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [CUR_W-1:0] rsp_avg_ff;
   logic [SOC_W-1:0]        rsp_soc_ff;
   logic                    rsp_socv_ff;

   logic [CMP_W-1:0]        sc_w, n_eff, seen_next;
   logic                    last, first, second;
   logic signed [SUM_W-1:0] x_ext;
   logic                    trim_neg, degenerate, below_low;
   logic [SUM_W-1:0]        trim_mag;
   logic [CUR_W-1:0]        q16;
   logic                    div_start;
   logic [DIV_W-1:0]        div_dividend, div_quotient;
   logic [DEN_W-1:0]        div_divisor;
   div_status_type          div_status;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= SAMPLE_COUNT_RST;
         volt_step_ff    <= VOLT_STEP_RST;
         volt_low_ff     <= VOLT_LOW_RST;
         volt_high_ff    <= VOLT_HIGH_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SAMPLE_COUNT: sample_count_ff <= csr_wdata[COUNT_CFG_W-1:0];
            CSR_VOLT_STEP:    volt_step_ff    <= csr_wdata[STEP_W-1:0];
            CSR_VOLT_LOW:     volt_low_ff     <= csr_wdata[MV_W-1:0];
            CSR_VOLT_HIGH:    volt_high_ff    <= csr_wdata[MV_W-1:0];
         endcase
      end
   end

   // effective batch length and end of batch detect
   always_comb begin
      sc_w      = CMP_W'(sample_count_ff);
      n_eff     = (sc_w < CMP_W'(MIN_COUNT)) ? CMP_W'(MIN_COUNT) :
                  ((sc_w > CMP_W'(MAX_SAMPLES)) ? CMP_W'(MAX_SAMPLES) : sc_w);
      seen_next = CMP_W'(seen_ff) + CMP_W'(1);
      last      = seen_next >= n_eff;
      first     = seen_ff == '0;
      second    = seen_ff == CNT_W'(1);
   end

   // per-sample update: sum and two smallest and two largest
   always_comb begin
      x_ext     = SUM_W'(current_code);
      seen_in   = seen_ff;
      sum_in    = sum_ff;
      bus_in    = bus_ff;
      small0_in = small0_ff;
      small1_in = small1_ff;
      large0_in = large0_ff;
      large1_in = large1_ff;
      if (cmd.accept) begin
         seen_in = last ? '0 : CNT_W'(seen_next);
         sum_in  = first ? x_ext : sum_ff + x_ext;
         if (first) begin
            bus_in    = bus_code;
            small0_in = current_code;
            large0_in = current_code;
         end else if (second) begin
            small0_in = (current_code < small0_ff) ? current_code : small0_ff;
            small1_in = (current_code < small0_ff) ? small0_ff : current_code;
            large0_in = (current_code < small0_ff) ? small0_ff : current_code;
            large1_in = (current_code < small0_ff) ? current_code : small0_ff;
         end else begin
            if (current_code < small0_ff) begin
               small1_in = small0_ff;
               small0_in = current_code;
            end else if (current_code < small1_ff) begin
               small1_in = current_code;
            end
            if (current_code > large0_ff) begin
               large1_in = large0_ff;
               large0_in = current_code;
            end else if (current_code > large1_ff) begin
               large1_in = current_code;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      bus_ff    <= bus_in;
      small0_ff <= small0_in;
      small1_ff <= small1_in;
      large0_ff <= large0_in;
      large1_ff <= large1_in;
   end

   // end of batch helpers
   always_comb begin
      trim_neg   = trimmed_ff[SUM_W-1];
      trim_mag   = trim_neg ? SUM_W'(-trimmed_ff) : SUM_W'(trimmed_ff);
      degenerate = volt_high_ff <= volt_low_ff;
      below_low  = uv_ff < UV_W'(low_uv_ff);
      q16        = div_quotient[CUR_W-1:0];
   end

   // shared divider: trimmed mean first, then charge estimate
   assign div_start    = cmd.mean_start | cmd.soc_start;
   assign div_dividend = cmd.soc_start ? soc_num_ff : DIV_W'(trim_mag);
   assign div_divisor  = cmd.soc_start ? (high_uv_ff - low_uv_ff)
                                       : DEN_W'(n_eff - CMP_W'(TRIM_DROP));

   tmcs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .status   (div_status)
   );

   // trimmed sum and voltage products
   always_ff @(posedge clock) begin
      if (cmd.trim) begin
         trimmed_ff <= sum_ff - SUM_W'(small0_ff) - SUM_W'(small1_ff)
                       - SUM_W'(large0_ff) - SUM_W'(large1_ff);
         uv_ff      <= UV_W'(bus_ff) * UV_W'(volt_step_ff);
         low_uv_ff  <= DEN_W'(volt_low_ff) * DEN_W'(MV_TO_UV);
         high_uv_ff <= DEN_W'(volt_high_ff) * DEN_W'(MV_TO_UV);
      end
   end

   // offset numerator: uv + high_uv - 2 * low_uv, then times 500
   always_ff @(posedge clock) begin
      if (cmd.mean_start) begin
         t_ff <= T_W'(uv_ff) + T_W'(high_uv_ff) - (T_W'(low_uv_ff) << 1);
      end
      if (cmd.mean_take) begin
         soc_num_ff <= DIV_W'(t_ff[T_W-2:0]) * DIV_W'(SOC_SCALE);
      end
   end

   // mean and charge estimate results
   always_ff @(posedge clock) begin
      if (cmd.mean_take) begin
         mean_ff <= trim_neg ? -$signed(q16) : $signed(q16);
         priority if (!trim_neg) begin
            soc_ff <= '0;
         end else if (degenerate) begin
            soc_ff <= below_low ? '0 : SOC_FULL;
         end else begin
            soc_ff <= '0;
         end
      end else if (cmd.soc_take) begin
         soc_ff <= (div_quotient > DIV_W'(SOC_FULL)) ? SOC_FULL : div_quotient[SOC_W-1:0];
      end
   end

   // result register: holds one transaction while the next batch runs
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_avg_ff  <= mean_ff;
         rsp_soc_ff  <= soc_ff;
         rsp_socv_ff <= trim_neg;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign avg_current_code = rsp_avg_ff;
   assign soc_permille     = rsp_soc_ff;
   assign soc_valid        = rsp_socv_ff;

   // status to the controller
   assign status.last_sample    = last;
   assign status.div_done       = div_status.done;
   assign status.div_busy       = div_status.busy;
   assign status.soc_div_needed = trim_neg & ~degenerate & ~t_ff[T_W-1];
   assign status.out_free       = ~rsp_valid_ff | rsp_ready;

endmodule

`default_nettype wire

>>> rtl/core/tmcs_ctrl.sv
// batch sequencer: sample intake, end of batch divisions and result hand-off
`default_nettype none

module tmcs_ctrl import tmcs_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd,
   output ctrl_state_type     state
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && status.last_sample) begin
               state_in = ST_TRIM;
            end
         end
         ST_TRIM: begin
            cmd.trim = 1'b1;
            state_in = ST_MEAN_START;
         end
         ST_MEAN_START: begin
            cmd.mean_start = 1'b1;
            state_in       = ST_MEAN_DIV;
         end
         ST_MEAN_DIV: begin
            if (status.div_done) begin
               cmd.mean_take = 1'b1;
               state_in      = status.soc_div_needed ? ST_SOC_START : ST_FINISH;
            end
         end
         ST_SOC_START: begin
            cmd.soc_start = 1'b1;
            state_in      = ST_SOC_DIV;
         end
         ST_SOC_DIV: begin
            if (status.div_done) begin
               cmd.soc_take = 1'b1;
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign state = state_ff;

endmodule

`default_nettype wire

>>> bench/trimmed_mean_current_soc_test.sv
// self-checking testbench of the trimmed mean current and charge estimate block
`default_nettype none

module trimmed_mean_current_soc_test;
   import tmcs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int BATCH_LIMIT     = 32;
   localparam int DRAIN_CYCLES    = 100;
   localparam int PHASE_COUNT     = 10;
   localparam int PHASE_SAMPLES   = 120;
   localparam int HOLD_CYCLES     = 400;

   // one finished batch as the result channel should show it
   typedef struct {
      logic signed [CUR_W-1:0] avg_current_code;
      logic [SOC_W-1:0]        soc_permille;
      logic                    soc_valid;
   } batch_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tmcs_req_if req_bus ();
   tmcs_rsp_if rsp_bus ();

   trimmed_mean_current_soc #(.MAX_SAMPLES(BATCH_LIMIT)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the registers
   logic [COUNT_CFG_W-1:0] count_cfg = SAMPLE_COUNT_RST;
   logic [STEP_W-1:0]      step_cfg  = VOLT_STEP_RST;
   logic [MV_W-1:0]        low_cfg   = VOLT_LOW_RST;
   logic [MV_W-1:0]        high_cfg  = VOLT_HIGH_RST;

   // predictor copy of the batch state
   int             batch_fill = 0;
   int             batch_sum  = 0;
   int             low_pair[2];
   int             high_pair[2];
   logic [BUS_W-1:0] batch_bus = '0;

   batch_result_type awaited_results[$];
   int failure_count = 0;

   // stimulus knobs
   bit req_idle_on     = 1'b1;
   bit rsp_stall_on    = 1'b1;
   int rsp_hold_cycles = 0;
   int batch_center;
   int batch_spread;

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   // charge estimate from the latched bus code, floor rounding, clamped
   function automatic logic [SOC_W-1:0] charge_permille();
      longint uv, low_uv, num, den, q, soc;
      longint bus_l, step_l, low_l, high_l;
      bus_l  = batch_bus;
      step_l = step_cfg;
      low_l  = low_cfg;
      high_l = high_cfg;
      uv     = bus_l * step_l;
      low_uv = low_l * MV_TO_UV;
      // empty or inverted window is a step at the low voltage
      if (high_l <= low_l)
         return (uv < low_uv) ? '0 : SOC_FULL;
      num = (uv - low_uv) * SOC_SCALE;
      den = (high_l - low_l) * MV_TO_UV;
      q   = num / den;
      if (num < 0 && (num % den) != 0)
         q = q - 1;
      soc = SOC_SCALE + q;
      if (soc < 0)
         soc = 0;
      if (soc > 1000)
         soc = 1000;
      return SOC_W'(soc);
   endfunction

   // fold one accepted sample into the batch, queue the result on the last one
   function automatic void absorb_sample(input logic signed [CUR_W-1:0] cur,
                                         input logic [BUS_W-1:0] bus);
      int x, n, trimmed, lo, hi;
      batch_result_type r;
      x = cur;
      n = count_cfg;
      if (n < MIN_COUNT)
         n = MIN_COUNT;
      if (n > BATCH_LIMIT)
         n = BATCH_LIMIT;
      if (batch_fill == 0) begin
         batch_bus    = bus;
         low_pair[0]  = x;
         high_pair[0] = x;
      end else if (batch_fill == 1) begin
         lo = (x < low_pair[0]) ? x : low_pair[0];
         hi = (x < low_pair[0]) ? low_pair[0] : x;
         low_pair[0]  = lo;
         low_pair[1]  = hi;
         high_pair[0] = hi;
         high_pair[1] = lo;
      end else begin
         if (x < low_pair[0]) begin
            low_pair[1] = low_pair[0];
            low_pair[0] = x;
         end else if (x < low_pair[1]) begin
            low_pair[1] = x;
         end
         if (x > high_pair[0]) begin
            high_pair[1] = high_pair[0];
            high_pair[0] = x;
         end else if (x > high_pair[1]) begin
            high_pair[1] = x;
         end
      end
      batch_sum  = batch_sum + x;
      batch_fill = batch_fill + 1;
      // a lowered count ends the batch as soon as the fill reaches or passes it
      if (batch_fill >= n) begin
         trimmed = batch_sum - low_pair[0] - low_pair[1] - high_pair[0] - high_pair[1];
         r.avg_current_code = CUR_W'(trimmed / (n - TRIM_DROP));
         r.soc_valid        = (trimmed < 0);
         r.soc_permille     = r.soc_valid ? charge_permille() : '0;
         awaited_results.insert(awaited_results.size(), r);
         batch_fill = 0;
         batch_sum  = 0;
      end
   endfunction

   // offer one sample, with an optional idle burst first, until accepted
   task automatic send_sample(input logic signed [CUR_W-1:0] cur,
                              input logic [BUS_W-1:0] bus);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.current_code <= cur;
      req_bus.bus_code     <= bus;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      absorb_sample(cur, bus);
   endtask

   // register write, one cycle, mirrored into the predictor
   task automatic write_setting(input csr_index_type reg_sel,
                                input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= reg_sel;
      csr_wdata <= value;
      @(posedge clock);
      case (reg_sel)
         CSR_SAMPLE_COUNT: count_cfg = value[COUNT_CFG_W-1:0];
         CSR_VOLT_STEP:    step_cfg  = value[STEP_W-1:0];
         CSR_VOLT_LOW:     low_cfg   = value[MV_W-1:0];
         CSR_VOLT_HIGH:    high_cfg  = value[MV_W-1:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // stop sending and wait until every batch result is back and the divider is done
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_all_settings(input logic [CSR_DATA_W-1:0] count_word,
                                     input logic [CSR_DATA_W-1:0] step_word,
                                     input logic [CSR_DATA_W-1:0] low_word,
                                     input logic [CSR_DATA_W-1:0] high_word);
      write_setting(CSR_SAMPLE_COUNT, count_word);
      write_setting(CSR_VOLT_STEP, step_word);
      write_setting(CSR_VOLT_LOW, low_word);
      write_setting(CSR_VOLT_HIGH, high_word);
   endtask

   // random settings, mostly short batches and a sane voltage window
   task automatic load_random_settings();
      logic [CSR_DATA_W-1:0] count_word, step_word, low_word, high_word;
      count_word = CSR_DATA_W'($urandom);
      if ($urandom_range(0, 3) != 0)
         count_word[COUNT_CFG_W-1:0] = COUNT_CFG_W'($urandom_range(5, 12));
      if ($urandom_range(0, 2) == 0)
         step_word = CSR_DATA_W'($urandom);
      else
         step_word = CSR_DATA_W'($urandom_range(1000, 8000));
      if ($urandom_range(0, 2) == 0)
         low_word = CSR_DATA_W'($urandom);
      else
         low_word = CSR_DATA_W'($urandom_range(8000, 20000));
      if ($urandom_range(0, 3) == 0)
         high_word = CSR_DATA_W'($urandom);
      else
         high_word = {1'($urandom), MV_W'(low_word[MV_W-1:0] + $urandom_range(1, 2000))};
      write_all_settings(count_word, step_word, low_word, high_word);
   endtask

   // first-sample bus code, usually landing around the voltage window
   function automatic logic [BUS_W-1:0] pick_bus();
      longint span, target, code, stp;
      int lo_mv, hi_mv;
      lo_mv = low_cfg;
      hi_mv = high_cfg;
      span  = hi_mv - lo_mv;
      if (span < 1)
         span = 1;
      if (step_cfg == '0 || $urandom_range(0, 3) == 0)
         return BUS_W'($urandom);
      stp    = step_cfg;
      target = longint'(lo_mv) * MV_TO_UV
             + longint'($urandom_range(0, 32'(3 * span * MV_TO_UV))) - span * MV_TO_UV;
      code   = target / stp;
      if (code < 0)
         code = 0;
      if (code > 8191)
         code = 8191;
      return BUS_W'(code);
   endfunction

   // current sample around the batch center, with full-range and extreme outliers
   function automatic logic signed [CUR_W-1:0] pick_current();
      int v;
      case ($urandom_range(0, 19))
         0: return CUR_W'($urandom);
         1: return -16'sd32768;
         2: return 16'sd32767;
         default: begin
            v = batch_center + int'($urandom_range(0, 2 * batch_spread)) - batch_spread;
            if (v > 32767)
               v = 32767;
            if (v < -32768)
               v = -32768;
            return CUR_W'(v);
         end
      endcase
   endfunction

   // result ready with random stall bursts and the occasional long hold
   initial begin : result_ready_driver
      rsp_bus.ready <= 1'b0;
      while (reset)
         @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else if (rsp_stall_on && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // compare each result transaction against the oldest awaited batch
   always @(posedge clock) begin
      batch_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_results.size() == 0) begin
            $error("unexpected result transaction: avg_current_code %0d soc %0d valid %0b",
                   rsp_bus.avg_current_code, rsp_bus.soc_permille, rsp_bus.soc_valid);
            failure_count = failure_count + 1;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_bus.avg_current_code !== want.avg_current_code) begin
               $error("avg_current_code: expected %0d, actual %0d",
                      want.avg_current_code, rsp_bus.avg_current_code);
               failure_count = failure_count + 1;
            end
            if (rsp_bus.soc_permille !== want.soc_permille) begin
               $error("soc_permille: expected %0d, actual %0d",
                      want.soc_permille, rsp_bus.soc_permille);
               failure_count = failure_count + 1;
            end
            if (rsp_bus.soc_valid !== want.soc_valid) begin
               $error("soc_valid: expected %0b, actual %0b",
                      want.soc_valid, rsp_bus.soc_valid);
               failure_count = failure_count + 1;
            end
         end
      end
   end

   // reset settings, trimmed sum of -1 that truncates to a zero mean but keeps soc
   task automatic test_default_batch();
      int currents[10] = '{100, -100, 9, -9, -1, 0, 0, 0, 0, 0};
      for (int i = 0; i < 10; i++)
         send_sample(CUR_W'(currents[i]), (i == 0) ? 13'd3100 : 13'd0);
   endtask

   // short count clamp, field extremes, floor rounding and an empty voltage window
   task automatic test_extremes_and_rounding();
      int small_drop[5] = '{-5, -3, -7, -1, -4};
      drain_results();
      write_all_settings(16'd0, 16'd1000, 16'd1000, 16'd1003);
      // below the window by a third of its width, quotient rounds down
      for (int i = 0; i < 5; i++)
         send_sample(CUR_W'(small_drop[i]), (i == 0) ? 13'd999 : 13'h1FFF);
      drain_results();
      write_setting(CSR_VOLT_HIGH, 16'd1000);
      // full-scale currents, top bus code, high equal to low
      for (int i = 0; i < 5; i++)
         send_sample((i % 2 == 0) ? -16'sd32768 : 16'sd32767, (i == 0) ? 13'h1FFF : 13'd0);
   endtask

   // count lowered to the current fill (0 clamps to 5) while a batch is open
   task automatic test_count_lowered();
      drain_results();
      write_all_settings(16'd6, 16'(VOLT_STEP_RST), 16'(VOLT_LOW_RST), 16'(VOLT_HIGH_RST));
      for (int i = 0; i < 5; i++)
         send_sample(CUR_W'(-10 * (i + 1)), 13'd0);
      drain_results();
      write_setting(CSR_SAMPLE_COUNT, 16'd0);
      send_sample(-16'sd60, 13'h0AAA);
   endtask

   // receiver holds off long enough for the block to stall its input
   task automatic test_result_backpressure();
      drain_results();
      req_idle_on  = 1'b0;
      rsp_stall_on = 1'b0;
      rsp_hold_cycles = HOLD_CYCLES;
      batch_center = -300;
      batch_spread = 500;
      for (int i = 0; i < 25; i++)
         send_sample(pick_current(), pick_bus());
   endtask

   // random phases, each with its own settings, the last one with no idling
   task automatic test_random_phases();
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_results();
         if (phase == PHASE_COUNT - 1) begin
            req_idle_on  = 1'b0;
            rsp_stall_on = 1'b0;
         end else begin
            req_idle_on  = ($urandom_range(0, 2) != 0);
            rsp_stall_on = ($urandom_range(0, 2) != 0);
         end
         if (phase == 0)
            write_all_settings(16'hFFFF, 16'hFFFF, 16'h0000, 16'h7FFF);
         else if (phase == 1)
            write_all_settings(16'h0000, 16'h0001, 16'h7FFF, 16'h7FFF);
         else
            load_random_settings();
         repeat (PHASE_SAMPLES) begin
            // new center and spread at each batch start
            if (batch_fill == 0) begin
               batch_center = int'($urandom_range(0, 4000)) - 2000;
               case ($urandom_range(0, 3))
                  0: batch_spread = 1;
                  1: batch_spread = 10;
                  2: batch_spread = 300;
                  default: batch_spread = 5000;
               endcase
            end
            send_sample(pick_current(), (batch_fill == 0) ? pick_bus() : BUS_W'($urandom));
         end
      end
   endtask

   // reset, test sequence, end of run
   initial begin
      req_bus.valid        <= 1'b0;
      req_bus.current_code <= '0;
      req_bus.bus_code     <= '0;
      csr_we               <= 1'b0;
      csr_index            <= CSR_SAMPLE_COUNT;
      csr_wdata            <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_batch();
      test_extremes_and_rounding();
      test_count_lowered();
      test_result_backpressure();
      test_random_phases();

      drain_results();
      if (failure_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl/core
rtl/core/tmcs_pkg.sv
rtl/core/tmcs_if.sv
rtl/core/tmcs_divider.sv
rtl/core/tmcs_datapath.sv
rtl/core/tmcs_ctrl.sv
rtl/core/trimmed_mean_current_soc.sv
bench/trimmed_mean_current_soc_test.sv
